@@ design/pct_pkg.sv @@
`default_nettype none
package pct_pkg;
	localparam int MaxSamples = 64;
	localparam int FracBits = 16;
	localparam int CntW = $clog2(MaxSamples + 1);

	typedef enum logic [3:0] {
		OP_LINE = 4'd0, OP_QUAD = 4'd1, OP_CUBIC = 4'd2, OP_RLINE = 4'd3,
		OP_RQUAD = 4'd4, OP_RCUBIC = 4'd5, OP_ORIGIN = 4'd6, OP_CLEAR = 4'd7,
		OP_CLOSE = 4'd8
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_REL, ST_TDIV, ST_LERP, ST_OUT
	} state_t;

	// Request to the shared interpolation unit.
	typedef struct packed {
		logic        start;
		logic [31:0] a;
		logic [31:0] b;
		logic [FracBits:0] t;
	} lerp_req_t;

	// Saturating 32-bit addition.
	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {a[31], a} + {b[31], b};
		if (s[32] != s[31])
			return s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
		return s[31:0];
	endfunction
endpackage
`default_nettype wire

@@ design/pct_lerp.sv @@
`default_nettype none
// Interpolation unit: a + floor(((b - a) * t + half) >> FracBits).
module pct_lerp (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire pct_pkg::lerp_req_t req,
	output logic                 done,
	output logic [31:0]          res
);
	logic signed [32:0] diff;
	logic signed [33+pct_pkg::FracBits:0] prod_s1;
	logic [31:0] a_s1;
	logic        v_s1;

	assign diff = $signed({req.b[31], req.b}) - $signed({req.a[31], req.a});

	// Multiply stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= req.start;
			done <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= diff * $signed({1'b0, req.t});
		a_s1    <= req.a;
	end

	// Round, shift and add stage.
	logic signed [33+pct_pkg::FracBits:0] rnd;
	assign rnd = prod_s1 + $signed((34+pct_pkg::FracBits)'(1) <<< (pct_pkg::FracBits - 1));
	always_ff @(posedge clk) begin
		res <= a_s1 + 32'(rnd >>> pct_pkg::FracBits);
	end
endmodule
`default_nettype wire

@@ design/pct_tdiv.sv @@
`default_nettype none
// Restoring divider for t = (2*i*2^F + d) / (2*d), one quotient bit a cycle.
module pct_tdiv (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [pct_pkg::CntW-1:0]   idx,
	input  wire logic [pct_pkg::CntW-1:0]   d,
	output logic                            done,
	output logic [pct_pkg::FracBits:0]      t
);
	localparam int NW = pct_pkg::CntW + pct_pkg::FracBits + 2;
	localparam int BW = $clog2(NW + 1);
	logic [NW-1:0] num_q;
	logic [NW:0]   rem_q;
	logic [NW:0]   div_q;
	logic [BW-1:0] bit_q;
	logic          busy_q;
	logic [NW:0]   trial;

	assign trial = {rem_q[NW-1:0], num_q[NW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			bit_q  <= '0;
			rem_q  <= '0;
			num_q  <= '0;
			div_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				bit_q  <= BW'(NW);
				rem_q  <= '0;
				num_q  <= (NW'(idx) << (pct_pkg::FracBits + 1)) + NW'(d);
				div_q  <= (NW+1)'(d) << 1;
			end else if (busy_q) begin
				if (trial >= div_q) begin
					rem_q <= trial - div_q;
					num_q <= {num_q[NW-2:0], 1'b1};
				end else begin
					rem_q <= trial;
					num_q <= {num_q[NW-2:0], 1'b0};
				end
				bit_q <= bit_q - BW'(1);
				if (bit_q == BW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end
	// Quotient bits accumulate in num_q as it shifts out.
	assign t = num_q[pct_pkg::FracBits:0];
endmodule
`default_nettype wire

@@ design/path_command_tessellator_core.sv @@
`default_nettype none
// Channel | Dir | Beat contents
// s_axis  | in  | tuser: operation; tdata: ax, ay, bx, by, cx, cy, sample_count
// m_axis  | out | tdata: px, py; tuser: is_origin, closed; tlast: last
// A curve point first divides for its t, then runs 6 (quad) or 12 (cubic) lerps
// on the shared unit, one after the other, and then gives one output beat.
// A command is taken in the idle state; lines, origin and clear then go to the
// output state, and relative commands first pass a state that adds the offsets.
// The input is not ready while a command is in work; output stalls hold it.
// Reset sets last point to zero, origin_only and clears the loop flag.
module path_command_tessellator_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// ax[31:0], ay, bx, by, cx, cy, sample_count[198:192], zero pad
	input  wire logic [199:0] s_axis_tdata,
	// operation[3:0]
	input  wire logic [3:0]   s_axis_tuser,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// px[31:0], py[63:32]
	output logic [63:0]       m_axis_tdata,
	// is_origin, closed
	output logic [1:0]        m_axis_tuser,
	output logic              m_axis_tlast
);
	localparam int CW = pct_pkg::CntW;
	pct_pkg::state_t st_q, st_d;
	logic [3:0] op_q;
	logic [31:0] p_q [0:7]; // x0,y0,ax,ay,bx,by,cx,cy
	logic [31:0] w_q [0:5];
	logic [CW-1:0] n1_q, i_q;
	logic [3:0] step_q;
	logic [pct_pkg::FracBits:0] t_q;
	logic [31:0] lx_q, ly_q;
	logic origin_only_q, loop_q;
	logic [31:0] ox_q, oy_q;
	logic org_q, fin_q, ov_q;
	logic lbusy_q;
	logic [6:0] sc;
	logic [3:0] in_op;
	pct_pkg::lerp_req_t lreq;
	logic ldone, tdone, tstart;
	logic [31:0] lres;
	logic [pct_pkg::FracBits:0] tval;

	assign in_op = s_axis_tuser;
	assign sc    = s_axis_tdata[198:192];
	assign s_axis_tready = (st_q == pct_pkg::ST_IDLE);
	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = {oy_q, ox_q};
	assign m_axis_tuser  = {loop_q, org_q};
	assign m_axis_tlast  = fin_q;

	pct_tdiv u_tdiv (.clk, .arst_n, .start(tstart), .idx(i_q), .d(n1_q),
		.done(tdone), .t(tval));
	pct_lerp u_lerp (.clk, .arst_n, .req(lreq), .done(ldone), .res(lres));

	// Lerp schedule: step selects operands from the working set.
	// Quad: w0=l(p0,a) w1=l(a,b) w2=l(w0,w1). Cubic: adds w2'=l(b,c) etc.
	logic [31:0] la, lb;
	logic [2:0]  wdst;
	logic        lastx;
	always_comb begin
		la = '0; lb = '0; wdst = '0;
		// Operands per step; x and y interleave by step[0].
		if (op_q == pct_pkg::OP_QUAD) begin
			case (step_q[3:1])
				3'd0: begin la = p_q[{2'd0,step_q[0]}]; lb = p_q[{2'd1,step_q[0]}]; wdst = 3'd0; end
				3'd1: begin la = p_q[{2'd1,step_q[0]}]; lb = p_q[{2'd2,step_q[0]}]; wdst = 3'd2; end
				default: begin la = w_q[{2'd0,step_q[0]}]; lb = w_q[{2'd1,step_q[0]}]; wdst = 3'd4; end
			endcase
		end else begin
			case (step_q[3:1])
				3'd0: begin la = p_q[{2'd0,step_q[0]}]; lb = p_q[{2'd1,step_q[0]}]; wdst = 3'd0; end
				3'd1: begin la = p_q[{2'd1,step_q[0]}]; lb = p_q[{2'd2,step_q[0]}]; wdst = 3'd2; end
				3'd2: begin la = p_q[{2'd2,step_q[0]}]; lb = p_q[{2'd3,step_q[0]}]; wdst = 3'd4; end
				3'd3: begin la = w_q[{2'd0,step_q[0]}]; lb = w_q[{2'd1,step_q[0]}]; wdst = 3'd0; end
				3'd4: begin la = w_q[{2'd1,step_q[0]}]; lb = w_q[{2'd2,step_q[0]}]; wdst = 3'd2; end
				default: begin la = w_q[{2'd0,step_q[0]}]; lb = w_q[{2'd1,step_q[0]}]; wdst = 3'd4; end
			endcase
		end
		lastx = (op_q == pct_pkg::OP_QUAD) ? (step_q == 4'd5) : (step_q == 4'd11);
	end
	assign lreq.start = (st_q == pct_pkg::ST_LERP) && !lbusy_q;
	assign lreq.a = la;
	assign lreq.b = lb;
	assign lreq.t = t_q;
	assign tstart = (st_q == pct_pkg::ST_TDIV) && !lbusy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= pct_pkg::ST_IDLE;
		else st_q <= st_d;
	end

	// Next state.
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			pct_pkg::ST_IDLE:
				if (s_axis_tvalid) begin
					if (in_op == pct_pkg::OP_RLINE || in_op == pct_pkg::OP_RQUAD ||
						in_op == pct_pkg::OP_RCUBIC) st_d = pct_pkg::ST_REL;
					else if (in_op == pct_pkg::OP_QUAD || in_op == pct_pkg::OP_CUBIC)
						st_d = pct_pkg::ST_TDIV;
					else if (in_op == pct_pkg::OP_LINE || in_op == pct_pkg::OP_ORIGIN ||
						in_op == pct_pkg::OP_CLEAR) st_d = pct_pkg::ST_OUT;
				end
			pct_pkg::ST_REL:
				st_d = (op_q == pct_pkg::OP_LINE) ? pct_pkg::ST_OUT : pct_pkg::ST_TDIV;
			pct_pkg::ST_TDIV:
				if (lbusy_q && tdone) st_d = pct_pkg::ST_LERP;
			pct_pkg::ST_LERP:
				if (lbusy_q && ldone && lastx) st_d = pct_pkg::ST_OUT;
			pct_pkg::ST_OUT:
				if (ov_q && m_axis_tready) begin
					if (fin_q) st_d = pct_pkg::ST_IDLE;
					else st_d = pct_pkg::ST_TDIV;
				end
			default: st_d = pct_pkg::ST_IDLE;
		endcase
	end

	// Datapath and path state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lx_q <= '0; ly_q <= '0; origin_only_q <= 1'b1; loop_q <= 1'b0;
			ov_q <= 1'b0; lbusy_q <= 1'b0; op_q <= '0; step_q <= '0;
			i_q <= '0; n1_q <= '0; org_q <= 1'b0; fin_q <= 1'b0;
			t_q <= '0; ox_q <= '0; oy_q <= '0;
			for (int k = 0; k < 8; k++) p_q[k] <= '0;
			for (int k = 0; k < 6; k++) w_q[k] <= '0;
		end else begin
			if (lreq.start || tstart) lbusy_q <= 1'b1;
			if (ov_q && m_axis_tready) ov_q <= 1'b0;
			unique case (st_q)
				pct_pkg::ST_IDLE:
					if (s_axis_tvalid) begin
						op_q <= (in_op == pct_pkg::OP_RLINE || in_op == pct_pkg::OP_RQUAD ||
							in_op == pct_pkg::OP_RCUBIC) ? in_op - pct_pkg::OP_RLINE : in_op;
						for (int k = 0; k < 6; k++) p_q[k+2] <= s_axis_tdata[32*k +: 32];
						p_q[0] <= lx_q; p_q[1] <= ly_q;
						n1_q <= (sc < 7'd2) ? CW'(1) :
							(sc > 7'(pct_pkg::MaxSamples)) ? CW'(pct_pkg::MaxSamples - 1) :
							CW'(sc - 7'd1);
						i_q <= CW'(1); step_q <= '0;
						if (in_op == pct_pkg::OP_CLOSE) loop_q <= 1'b1;
						if (in_op == pct_pkg::OP_LINE) begin
							ox_q <= s_axis_tdata[31:0]; oy_q <= s_axis_tdata[63:32];
							lx_q <= s_axis_tdata[31:0]; ly_q <= s_axis_tdata[63:32];
							origin_only_q <= 1'b0; org_q <= 1'b0; fin_q <= 1'b1; ov_q <= 1'b1;
						end
						if (in_op == pct_pkg::OP_ORIGIN || in_op == pct_pkg::OP_CLEAR) begin
							ox_q <= s_axis_tdata[31:0]; oy_q <= s_axis_tdata[63:32];
							org_q <= 1'b1; fin_q <= 1'b1; ov_q <= 1'b1;
							if (origin_only_q || in_op == pct_pkg::OP_CLEAR) begin
								lx_q <= s_axis_tdata[31:0]; ly_q <= s_axis_tdata[63:32];
							end
							if (in_op == pct_pkg::OP_CLEAR) begin
								origin_only_q <= 1'b1; loop_q <= 1'b0;
							end
						end
					end
				pct_pkg::ST_REL: begin
					for (int k = 2; k < 8; k++)
						p_q[k] <= pct_pkg::sat_add(k[0] ? ly_q : lx_q, p_q[k]);
					if (op_q == pct_pkg::OP_LINE) begin
						ox_q <= pct_pkg::sat_add(lx_q, p_q[2]);
						oy_q <= pct_pkg::sat_add(ly_q, p_q[3]);
						lx_q <= pct_pkg::sat_add(lx_q, p_q[2]);
						ly_q <= pct_pkg::sat_add(ly_q, p_q[3]);
						origin_only_q <= 1'b0; org_q <= 1'b0; fin_q <= 1'b1; ov_q <= 1'b1;
					end
				end
				pct_pkg::ST_TDIV:
					if (lbusy_q && tdone) begin
						t_q <= tval; lbusy_q <= 1'b0; step_q <= '0;
					end
				pct_pkg::ST_LERP:
					if (lbusy_q && ldone) begin
						lbusy_q <= 1'b0;
						w_q[wdst + {2'd0, step_q[0]}] <= lres;
						step_q <= step_q + 4'd1;
						if (lastx && step_q[0]) begin
							ox_q <= w_q[4]; oy_q <= lres;
							lx_q <= w_q[4]; ly_q <= lres;
							org_q <= 1'b0; fin_q <= (i_q == n1_q); ov_q <= 1'b1;
							origin_only_q <= 1'b0;
						end
					end
				pct_pkg::ST_OUT:
					if (ov_q && m_axis_tready) i_q <= i_q + CW'(1);
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ design/pct_checker.sv @@
`default_nettype none
module pct_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	input wire logic s_axis_tready,
	input wire logic m_axis_tvalid,
	input wire logic m_axis_tready,
	input wire logic [63:0] m_axis_tdata,
	input wire logic [1:0] m_axis_tuser,
	input wire logic m_axis_tlast
);
	// A stalled output beat holds its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			$stable({m_axis_tdata, m_axis_tuser, m_axis_tlast}))
		else $error("output beat changed under stall");
	// A stalled output beat stays valid.
	a_keep: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output beat dropped under stall");
	// No new input while an output beat is pending.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input ready with pending output");
	// An origin beat always ends its command.
	a_org: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
		else $error("origin beat without last");
endmodule
bind path_command_tessellator_core pct_checker u_chk (.*);
`default_nettype wire

@@ tb/path_command_tessellator_checker.sv @@
`timescale 1ns / 100ps

module path_command_tessellator_checker (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	input  wire logic         s_axis_tready,
	input  wire logic [199:0] s_axis_tdata,
	input  wire logic [3:0]   s_axis_tuser,
	input  wire logic         m_axis_tvalid,
	input  wire logic         m_axis_tready,
	input  wire logic [63:0]  m_axis_tdata,
	input  wire logic [1:0]   m_axis_tuser,
	input  wire logic         m_axis_tlast,
	output int                pending_points,
	output int                fail_count
);
	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic               is_origin;
		logic               last;
		logic               closed;
	} point_t;

	// Shadow of the block's path state.
	logic signed [31:0] cur_x, cur_y;
	logic               only_origin;
	logic               loop_closed;
	point_t             point_queue[$];

	assign pending_points = point_queue.size();

	function automatic logic signed [31:0] sat_sum(logic signed [31:0] a,
			logic signed [31:0] b);
		longint s;
		s = longint'(a) + longint'(b);
		if (s > 64'sd2147483647)
			s = 64'sd2147483647;
		if (s < -64'sd2147483648)
			s = -64'sd2147483648;
		return s[31:0];
	endfunction

	// Interpolation with round-half-up and a floor shift.
	function automatic logic signed [31:0] interp(logic signed [31:0] a,
			logic signed [31:0] b, int unsigned t);
		longint prod;
		prod = (longint'(b) - longint'(a)) * longint'(t) +
			(64'sd1 <<< (pct_pkg::FracBits - 1));
		return 32'(longint'(a) + (prod >>> pct_pkg::FracBits));
	endfunction

	function automatic point_t make_point(logic signed [31:0] x, logic signed [31:0] y,
			logic org, logic fin, logic cl);
		point_t p;
		p.px = x;
		p.py = y;
		p.is_origin = org;
		p.last = fin;
		p.closed = cl;
		return p;
	endfunction

	// Append one expected point at the tail of the queue.
	function automatic void queue_point(point_t p);
		point_queue = {point_queue, p};
	endfunction

	// Predict the points caused by one accepted command beat.
	task automatic predict_command(logic [3:0] op, logic [199:0] d);
		logic [3:0] code;
		logic signed [31:0] ax, ay, bx, by, cx, cy, x0, y0, x, y;
		logic signed [31:0] qx0, qx1, qx2, qy0, qy1, qy2;
		int unsigned n, t;
		longint unsigned dn;
		code = op;
		ax = d[31:0];
		ay = d[63:32];
		bx = d[95:64];
		by = d[127:96];
		cx = d[159:128];
		cy = d[191:160];
		n = d[198:192];
		if (n < 2)
			n = 2;
		if (n > pct_pkg::MaxSamples)
			n = pct_pkg::MaxSamples;
		if (code == pct_pkg::OP_RLINE || code == pct_pkg::OP_RQUAD ||
				code == pct_pkg::OP_RCUBIC) begin
			ax = sat_sum(cur_x, ax);
			ay = sat_sum(cur_y, ay);
			bx = sat_sum(cur_x, bx);
			by = sat_sum(cur_y, by);
			cx = sat_sum(cur_x, cx);
			cy = sat_sum(cur_y, cy);
			code = code - pct_pkg::OP_RLINE;
		end
		case (code)
			pct_pkg::OP_LINE: begin
				cur_x = ax;
				cur_y = ay;
				only_origin = 1'b0;
				queue_point(make_point(ax, ay, 1'b0, 1'b1, loop_closed));
			end
			pct_pkg::OP_QUAD, pct_pkg::OP_CUBIC: begin
				x0 = cur_x;
				y0 = cur_y;
				dn = n - 1;
				for (int unsigned i = 1; i < n; i++) begin
					t = int'(((longint'(i) << pct_pkg::FracBits) * 2 + dn) / (2 * dn));
					if (code == pct_pkg::OP_QUAD) begin
						x = interp(interp(x0, ax, t), interp(ax, bx, t), t);
						y = interp(interp(y0, ay, t), interp(ay, by, t), t);
					end else begin
						qx0 = interp(x0, ax, t);
						qx1 = interp(ax, bx, t);
						qx2 = interp(bx, cx, t);
						qy0 = interp(y0, ay, t);
						qy1 = interp(ay, by, t);
						qy2 = interp(by, cy, t);
						x = interp(interp(qx0, qx1, t), interp(qx1, qx2, t), t);
						y = interp(interp(qy0, qy1, t), interp(qy1, qy2, t), t);
					end
					queue_point(make_point(x, y, 1'b0, i == n - 1, loop_closed));
					cur_x = x;
					cur_y = y;
				end
				only_origin = 1'b0;
			end
			pct_pkg::OP_ORIGIN: begin
				if (only_origin) begin
					cur_x = ax;
					cur_y = ay;
				end
				queue_point(make_point(ax, ay, 1'b1, 1'b1, loop_closed));
			end
			pct_pkg::OP_CLEAR: begin
				cur_x = ax;
				cur_y = ay;
				only_origin = 1'b1;
				loop_closed = 1'b0;
				queue_point(make_point(ax, ay, 1'b1, 1'b1, 1'b0));
			end
			pct_pkg::OP_CLOSE: loop_closed = 1'b1;
			default: ;
		endcase
	endtask

	// Watch both channels on every rising edge.
	always @(posedge clk or negedge arst_n) begin
		point_t got, want;
		if (!arst_n) begin
			cur_x = '0;
			cur_y = '0;
			only_origin = 1'b1;
			loop_closed = 1'b0;
			fail_count = 0;
			point_queue.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = make_point(m_axis_tdata[31:0], m_axis_tdata[63:32],
					m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1]);
				if (point_queue.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected point beat, expected none, actual x=%h y=%h",
						$time, got.px, got.py);
				end else begin
					want = point_queue.pop_front();
					if (got !== want) begin
						fail_count++;
						$display("%0t: point mismatch, expected x=%h y=%h org=%b last=%b cl=%b,",
							$time, want.px, want.py, want.is_origin, want.last, want.closed);
						$display("    actual x=%h y=%h org=%b last=%b cl=%b",
							got.px, got.py, got.is_origin, got.last, got.closed);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				predict_command(s_axis_tuser, s_axis_tdata);
		end
	end
endmodule

@@ tb/path_command_tessellator_core_tb.sv @@
`timescale 1ns / 100ps

module path_command_tessellator_core_tb;
	localparam longint CycleLimit = 20000000;
	localparam int RandomCommands = 500;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [199:0] s_axis_tdata;
	logic [3:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [63:0]  m_axis_tdata;
	logic [1:0]   m_axis_tuser;
	logic         m_axis_tlast;
	int           pending_points;
	int           fail_count;
	logic         steady_flow;
	longint       cycle_count;

	path_command_tessellator_core uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	path_command_tessellator_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.pending_points(pending_points), .fail_count(fail_count)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Output side stalls at random unless the steady stretch is on.
	always @(negedge clk)
		m_axis_tready <= steady_flow ? 1'b1 : ($urandom_range(0, 99) >= 35);

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Send one command beat and wait for it to be taken.
	task automatic send_command(logic [3:0] code, logic [31:0] ax, logic [31:0] ay,
			logic [31:0] bx, logic [31:0] by, logic [31:0] cx, logic [31:0] cy,
			logic [6:0] n);
		if (!steady_flow)
			while ($urandom_range(0, 99) < 35) begin
				s_axis_tvalid = 1'b0;
				@(negedge clk);
			end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {1'b0, n, cy, cx, by, bx, ay, ax};
		s_axis_tuser = code;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	function automatic logic [31:0] pick_coord();
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0: return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
			1, 2, 3: return $urandom;
			default: return 32'($signed($urandom_range(0, 2097152)) - 1048576);
		endcase
	endfunction

	function automatic logic [6:0] pick_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 7'($urandom_range(2, 8));
		if (r < 90)
			return 7'($urandom_range(9, 32));
		if (r < 96)
			return 7'($urandom_range(33, 64));
		return 7'($urandom_range(0, 127));
	endfunction

	function automatic logic [3:0] pick_code();
		int r;
		r = $urandom_range(0, 99);
		if (r < 78)
			return 4'($urandom_range(pct_pkg::OP_LINE, pct_pkg::OP_RCUBIC));
		if (r < 85)
			return pct_pkg::OP_ORIGIN;
		if (r < 90)
			return pct_pkg::OP_CLEAR;
		if (r < 95)
			return pct_pkg::OP_CLOSE;
		return 4'($urandom_range(9, 15));
	endfunction

	initial begin
		int idle_wait;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		steady_flow = 1'b0;
		cycle_count = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: origin handling, every operation, sample count limits.
		send_command(pct_pkg::OP_ORIGIN, 32'h0001_0000, 32'hffff_0000, 0, 0, 0, 0, 7'd2);
		send_command(pct_pkg::OP_LINE, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 0, 7'd2);
		send_command(pct_pkg::OP_ORIGIN, 32'h1234_5678, 32'h8765_4321, 0, 0, 0, 0, 7'd2);
		send_command(pct_pkg::OP_QUAD, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h8000_0000, 0, 0, 7'd0);
		send_command(pct_pkg::OP_CUBIC, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
			32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 7'd64);
		send_command(pct_pkg::OP_QUAD, 32'h0010_0000, 32'h0020_0000, 32'hfff0_0000,
			32'h0000_8000, 0, 0, 7'd1);
		send_command(pct_pkg::OP_CUBIC, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
			32'h0004_0000, 32'h0005_0000, 32'h0006_0000, 7'd65);
		send_command(pct_pkg::OP_CLOSE, 0, 0, 0, 0, 0, 0, 7'd2);
		send_command(pct_pkg::OP_RLINE, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 0, 7'd2);
		send_command(pct_pkg::OP_RLINE, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 0, 7'd2);
		send_command(pct_pkg::OP_RQUAD, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff,
			32'h0000_0001, 0, 0, 7'd127);
		send_command(pct_pkg::OP_RCUBIC, 32'h0000_1000, 32'hffff_f000, 32'h8000_0000,
			32'h7fff_ffff, 32'h0001_0000, 32'hffff_0000, 7'd3);
		send_command(4'd9, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
			32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 7'd127);
		send_command(4'd15, 0, 0, 0, 0, 0, 0, 7'd2);
		send_command(pct_pkg::OP_CLEAR, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0, 0, 7'd2);
		send_command(pct_pkg::OP_ORIGIN, 32'h0000_0001, 32'h0000_0002, 0, 0, 0, 0, 7'd2);
		send_command(pct_pkg::OP_RQUAD, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000,
			32'h0000_0000, 0, 0, 7'd5);
		send_command(pct_pkg::OP_CLOSE, 0, 0, 0, 0, 0, 0, 7'd2);
		send_command(pct_pkg::OP_LINE, 32'hffff_ffff, 32'h0000_0000, 0, 0, 0, 0, 7'd2);
		send_command(pct_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 7'd2);

		// Hold the sender until the block has drained.
		while (pending_points != 0)
			@(negedge clk);

		// Random paths, with a stretch of full-rate traffic in the middle.
		for (int k = 0; k < RandomCommands; k++) begin
			steady_flow = (k >= 200 && k < 280);
			send_command(pick_code(), pick_coord(), pick_coord(), pick_coord(),
				pick_coord(), pick_coord(), pick_coord(), pick_count());
			if (k == 350)
				while (pending_points != 0)
					@(negedge clk);
		end
		steady_flow = 1'b0;

		while (pending_points != 0)
			@(negedge clk);
		repeat (200) @(negedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

@@ sim.f @@
design/pct_pkg.sv
design/pct_lerp.sv
design/pct_tdiv.sv
design/path_command_tessellator_core.sv
design/pct_checker.sv
tb/path_command_tessellator_checker.sv
tb/path_command_tessellator_core_tb.sv
